### src/pmic_rcr_pkg.sv
// Shared types, codes and per-channel range tables for the regulator control block.
// No dependencies; every other file in src imports this package.
package pmic_rcr_pkg;

	localparam int NumChannels = 14;
	localparam int ChanW       = 4;
	localparam int CodeW       = 6;
	localparam int UvW         = 22;

	// Fixed-output channels
	localparam logic [ChanW-1:0] ChanFixedLo = 4'd2;
	localparam logic [ChanW-1:0] ChanFixedHi = 4'd13;
	localparam logic [UvW-1:0]   FixedLoUv   = 22'd1250000;
	localparam logic [UvW-1:0]   FixedHiUv   = 22'd3300000;

	// Highest voltage any channel can report
	localparam logic [UvW-1:0]   VMaxAllUv   = 22'd3400000;

	// ceil(2^30 / 3125); exact floor division for any 19-bit dividend
	localparam int               RecipShift  = 30;
	localparam logic [18:0]      Recip3125   = 19'd343598;

	typedef enum logic [1:0] {
		KIND_SET_EN   = 2'd0,
		KIND_GET_EN   = 2'd1,
		KIND_SET_VOLT = 2'd2,
		KIND_GET_VOLT = 2'd3
	} kind_t;

	// Voltage range classes
	typedef enum logic [2:0] {
		RNG_BUCK,    // 712.5 mV .. 1.5 V, 12.5 mV step
		RNG_BUCK4,   // 1.8 V .. 3.3 V, 100 mV step
		RNG_LDO_HI,  // 1.8 V .. 3.4 V, 100 mV step
		RNG_LDO_LO,  // 0.8 V .. 2.5 V, 100 mV step
		RNG_FIXED    // no selector, fixed output
	} range_t;

	typedef struct packed {
		kind_t              kind;
		logic [ChanW-1:0]   channel;
		logic               enable_in;
		logic [UvW-1:0]     voltage_in_uv;
	} req_t;

	typedef struct packed {
		logic               enabled;
		logic [UvW-1:0]     voltage_out_uv;
		logic [CodeW-1:0]   selector_code;
	} rsp_t;

	// Datapath results handed back to the control stage
	typedef struct packed {
		logic [CodeW-1:0]   new_code;
		logic [UvW-1:0]     vout;
	} volt_res_t;

	function automatic range_t chan_range(input logic [ChanW-1:0] ch);
		range_t r;
		case (ch)
			4'd0, 4'd1:                         r = RNG_BUCK;
			4'd3:                               r = RNG_BUCK4;
			4'd4, 4'd5, 4'd7, 4'd8, 4'd11, 4'd12: r = RNG_LDO_HI;
			4'd6, 4'd9, 4'd10:                  r = RNG_LDO_LO;
			default:                            r = RNG_FIXED;
		endcase
		return r;
	endfunction

	function automatic logic [UvW-1:0] rng_min(input range_t r);
		logic [UvW-1:0] v;
		case (r)
			RNG_BUCK:                v = 22'd712500;
			RNG_BUCK4, RNG_LDO_HI:   v = 22'd1800000;
			RNG_LDO_LO:              v = 22'd800000;
			default:                 v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [UvW-1:0] rng_max(input range_t r);
		logic [UvW-1:0] v;
		case (r)
			RNG_BUCK:    v = 22'd1500000;
			RNG_BUCK4:   v = 22'd3300000;
			RNG_LDO_HI:  v = 22'd3400000;
			RNG_LDO_LO:  v = 22'd2500000;
			default:     v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [16:0] rng_step(input range_t r);
		logic [16:0] s;
		case (r)
			RNG_BUCK:                          s = 17'd12500;
			RNG_BUCK4, RNG_LDO_HI, RNG_LDO_LO: s = 17'd100000;
			default:                           s = 17'd1;
		endcase
		return s;
	endfunction

endpackage

### src/pmic_rcr_if.sv
// Valid/ready channel interfaces for operation and result beats.
// Depends on pmic_rcr_pkg for the payload types.
interface pmic_rcr_req_if;
	import pmic_rcr_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface pmic_rcr_rsp_if;
	import pmic_rcr_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### src/pmic_rcr_volt.sv
// Voltage datapath: microvolts to selector code and selector code to microvolts.
// Depends on pmic_rcr_pkg for range tables and constants.
module pmic_rcr_volt (
	input  logic [pmic_rcr_pkg::ChanW-1:0] channel,
	input  logic [pmic_rcr_pkg::UvW-1:0]   voltage_in_uv,
	input  logic [pmic_rcr_pkg::CodeW-1:0] code_cur,
	output pmic_rcr_pkg::volt_res_t        res
);
	import pmic_rcr_pkg::*;

	range_t         rng;
	logic [UvW-1:0] vmin;
	logic [UvW-1:0] vmax;
	logic [16:0]    step;
	logic [UvW-1:0] vclamp;
	logic [20:0]    vdelta;
	logic [20:0]    biased;
	logic [18:0]    scaled;
	logic [37:0]    quot_prod;
	logic [22:0]    mul_step;
	logic [23:0]    vsum;

	assign rng  = chan_range(channel);
	assign vmin = rng_min(rng);
	assign vmax = rng_max(rng);
	assign step = rng_step(rng);

	// Set path: clamp, then ceil((v - min) / step).
	// Both steps are 3125 times a power of two, so pre-shift then one reciprocal multiply.
	always_comb begin
		if (voltage_in_uv < vmin) begin
			vclamp = vmin;
		end else if (voltage_in_uv > vmax) begin
			vclamp = vmax;
		end else begin
			vclamp = voltage_in_uv;
		end
	end

	assign vdelta    = 21'(vclamp - vmin);
	assign biased    = vdelta + 21'(step) - 21'd1;
	assign scaled    = (rng == RNG_BUCK) ? biased[20:2] : {3'b000, biased[20:5]};
	assign quot_prod = {19'b0, scaled} * {19'b0, Recip3125};
	assign res.new_code = quot_prod[RecipShift +: CodeW];

	// Get path: code * step + min, capped at max; fixed channels report their constant
	assign mul_step = 23'(code_cur) * 23'(step);
	assign vsum     = {1'b0, mul_step} + {2'b00, vmin};

	always_comb begin
		if (channel == ChanFixedLo) begin
			res.vout = FixedLoUv;
		end else if (channel == ChanFixedHi) begin
			res.vout = FixedHiUv;
		end else if (vsum > {2'b00, vmax}) begin
			res.vout = vmax;
		end else begin
			res.vout = vsum[UvW-1:0];
		end
	end

endmodule

### src/pmic_regulator_control_regs.sv
// Regulator control block for 14 channels (bucks 1-4, LDO1-9, one switch): set and get
// of enable and voltage. An operation beat is registered at the input, processed in one
// pass through the voltage datapath (one 19x19 reciprocal multiply for the step division)
// and lands in a result register: one beat per cycle while the sink keeps up. Each beat
// moves from the input register to the result register, and a result held back by the
// sink stalls the input. Every operation yields exactly one result beat. Enable and
// selector state reset to zero. Depends on pmic_rcr_pkg, pmic_rcr_if and pmic_rcr_volt.
module pmic_regulator_control_regs (
	input  logic            clk,
	input  logic            arst_n,
	pmic_rcr_req_if.sink    req,
	pmic_rcr_rsp_if.source  rsp
);
	import pmic_rcr_pkg::*;

	// Input stage
	logic              valid_s1;
	req_t              req_s1;
	// Result stage
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	// Channel state: one enable per channel (maps onto the DCDC/LDO enable bytes)
	logic [NumChannels-1:0] en_q;
	logic [CodeW-1:0]       code_q [NumChannels];

	logic              advance;
	logic              ch_ok;
	logic              is_fixed;
	logic [CodeW-1:0]  code_cur;
	logic              en_cur;
	volt_res_t         vres;
	rsp_t              rsp_d;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	// Lookup of current channel state
	assign ch_ok    = req_s1.channel < ChanW'(NumChannels);
	assign is_fixed = chan_range(req_s1.channel) == RNG_FIXED;
	assign code_cur = ch_ok ? code_q[req_s1.channel] : '0;
	assign en_cur   = ch_ok ? en_q[req_s1.channel] : 1'b0;

	pmic_rcr_volt u_volt (
		.channel       (req_s1.channel),
		.voltage_in_uv (req_s1.voltage_in_uv),
		.code_cur      (code_cur),
		.res           (vres)
	);

	// Result assembly; out-of-range channels give all zeros
	always_comb begin
		rsp_d = '0;
		if (ch_ok) begin
			rsp_d.enabled       = (req_s1.kind == KIND_SET_EN) ? req_s1.enable_in : en_cur;
			rsp_d.selector_code = (req_s1.kind == KIND_SET_VOLT && !is_fixed) ?
				vres.new_code : code_cur;
			rsp_d.voltage_out_uv = (req_s1.kind == KIND_GET_VOLT) ? vres.vout : '0;
		end
	end

	// State update, once per beat as it leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
			for (int i = 0; i < NumChannels; i++) begin
				code_q[i] <= '0;
			end
		end else if (advance && ch_ok) begin
			if (req_s1.kind == KIND_SET_EN) begin
				en_q[req_s1.channel] <= req_s1.enable_in;
			end
			if (req_s1.kind == KIND_SET_VOLT && !is_fixed) begin
				code_q[req_s1.channel] <= vres.new_code;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Checks
	a_bad_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !ch_ok |=> rsp_q == '0)
		else $error("out-of-range channel gave a nonzero result");

	a_fixed_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		code_q[ChanFixedLo] == '0 && code_q[ChanFixedHi] == '0)
		else $error("fixed channel selector was written");

	a_vout_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.voltage_out_uv <= VMaxAllUv)
		else $error("reported voltage above the highest channel maximum");

	a_set_code_stored: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ch_ok && !is_fixed && req_s1.kind == KIND_SET_VOLT
		|=> code_q[$past(req_s1.channel)] == rsp_q.selector_code)
		else $error("stored selector differs from reported selector");

endmodule

### dv/testbench.sv
// Self-checking testbench for pmic_regulator_control_regs: enable and voltage set/get traffic.
// Depends on pmic_rcr_pkg, pmic_rcr_if and the block's RTL; holds its own regulator predictor.
`timescale 1ns / 1ps

module testbench;
	import pmic_rcr_pkg::*;

	typedef enum int {
		RDY_ALWAYS,
		RDY_SKIP4,
		RDY_COIN,
		RDY_LONG_STALL
	} rdy_mode_t;

	typedef struct {
		req_t op;
		rsp_t rsp;
	} pending_t;

	logic clk;
	logic arst_n;

	pmic_rcr_req_if op_bus ();
	pmic_rcr_rsp_if res_bus ();

	pmic_regulator_control_regs dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (op_bus),
		.rsp    (res_bus)
	);

	// Predictor state: enable bits as {ldo byte, dcdc byte}, selector code per channel
	logic [15:0]      enable_regs;
	logic [CodeW-1:0] sel_codes [NumChannels];

	pending_t    pending_q [$];
	int unsigned fail_count;
	int unsigned mismatch_count;
	int unsigned results_checked;
	int unsigned ops_by_kind [4];
	int unsigned ops_sent;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// Range of a channel; fixed and unmapped channels report no selector range
	function automatic void chan_limits(input logic [ChanW-1:0] ch, output int unsigned stepv,
			output int unsigned vmin, output int unsigned vmax, output bit fixed);
		fixed = 1'b0;
		case (ch)
			4'd0, 4'd1: begin
				stepv = 12500; vmin = 712500; vmax = 1500000;
			end
			4'd3: begin
				stepv = 100000; vmin = 1800000; vmax = 3300000;
			end
			4'd4, 4'd5, 4'd7, 4'd8, 4'd11, 4'd12: begin
				stepv = 100000; vmin = 1800000; vmax = 3400000;
			end
			4'd6, 4'd9, 4'd10: begin
				stepv = 100000; vmin = 800000; vmax = 2500000;
			end
			default: begin
				stepv = 1; vmin = 0; vmax = 0; fixed = 1'b1;
			end
		endcase
	endfunction

	// Applies one operation to the predictor state and returns the result beat
	function automatic rsp_t predict_result(input req_t op);
		rsp_t        r;
		int unsigned stepv, vmin, vmax, v, vout, ch, en_idx;
		bit          fixed;
		r = '0;
		ch = op.channel;
		if (ch >= NumChannels)
			return r;
		chan_limits(op.channel, stepv, vmin, vmax, fixed);
		// bucks on dcdc bits 0-3, LDO1-8 on the ldo byte, LDO9 and switch on dcdc bits 5-6
		if (ch <= 3)
			en_idx = ch;
		else if (ch <= 11)
			en_idx = ch + 4;
		else
			en_idx = ch - 7;
		vout = 0;
		case (op.kind)
			KIND_SET_EN: enable_regs[en_idx] = op.enable_in;
			KIND_SET_VOLT: begin
				if (!fixed) begin
					v = op.voltage_in_uv;
					if (v < vmin)
						v = vmin;
					else if (v > vmax)
						v = vmax;
					sel_codes[ch] = CodeW'((v - vmin + stepv - 1) / stepv);
				end
			end
			KIND_GET_VOLT: begin
				if (ch == 2)
					vout = 1250000;
				else if (ch == 13)
					vout = 3300000;
				else begin
					vout = sel_codes[ch] * stepv + vmin;
					if (vout > vmax)
						vout = vmax;
				end
			end
			default: ;
		endcase
		r.enabled        = enable_regs[en_idx];
		r.voltage_out_uv = UvW'(vout);
		r.selector_code  = sel_codes[ch];
		return r;
	endfunction

	function automatic req_t make_op(input kind_t kind, input int unsigned ch,
			input bit en, input int unsigned uv);
		req_t op;
		op.kind          = kind;
		op.channel       = ChanW'(ch);
		op.enable_in     = en;
		op.voltage_in_uv = UvW'(uv);
		return op;
	endfunction

	// Mostly mapped channels, now and then one of the two channels past the end
	function automatic int unsigned pick_channel();
		if ($urandom_range(0, 99) < 4)
			return $urandom_range(14, 15);
		return $urandom_range(0, NumChannels - 1);
	endfunction

	// Voltages around the channel's range, on step edges, or anywhere in the field
	function automatic int unsigned pick_voltage(input int unsigned ch);
		int unsigned stepv, vmin, vmax, mode;
		bit          fixed;
		chan_limits(ChanW'(ch), stepv, vmin, vmax, fixed);
		mode = $urandom_range(0, 9);
		if (fixed || mode >= 8)
			return $urandom_range(0, 22'h3FFFFF);
		if (mode == 7)
			return vmin + stepv * $urandom_range(0, (vmax - vmin) / stepv) + $urandom_range(0, 1);
		return $urandom_range(vmin - 2 * stepv, vmax + 2 * stepv);
	endfunction

	// Drives one operation beat; returns at the accepting edge
	task automatic send_op(input req_t op);
		pending_t p;
		op_bus.valid <= 1'b1;
		op_bus.data  <= op;
		do
			@(negedge clk);
		while (!op_bus.ready);
		p.op  = op;
		p.rsp = predict_result(op);
		pending_q.push_back(p);
		ops_by_kind[op.kind]++;
		ops_sent++;
		@(posedge clk);
	endtask

	task automatic idle_cycles(input int unsigned n);
		op_bus.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Holds off new operations until every outstanding result has come back
	task automatic wait_drain();
		op_bus.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver stall pattern: picks a random mode for each randomly sized span
	initial begin
		rdy_mode_t   mode;
		int unsigned span, phase;
		res_bus.ready <= 1'b0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			mode = rdy_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 80);
			repeat (span) begin
				@(posedge clk);
				phase++;
				case (mode)
					RDY_ALWAYS:     res_bus.ready <= 1'b1;
					RDY_SKIP4:      res_bus.ready <= (phase % 4) != 0;
					RDY_COIN:       res_bus.ready <= $urandom_range(0, 1);
					RDY_LONG_STALL: res_bus.ready <= (phase % 16) >= 10;
					default:        res_bus.ready <= 1'b1;
				endcase
			end
		end
	end

	// Result checker: outputs are stable at the falling edge before the accepting edge
	always @(negedge clk) begin
		pending_t p;
		rsp_t     got;
		if (arst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			got = res_bus.data;
			results_checked++;
			if (pending_q.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("ERROR: result beat with nothing outstanding: en=%0b uv=%0d code=%0d",
						got.enabled, got.voltage_out_uv, got.selector_code);
			end else begin
				p = pending_q.pop_front();
				if (got.enabled !== p.rsp.enabled ||
						got.voltage_out_uv !== p.rsp.voltage_out_uv ||
						got.selector_code !== p.rsp.selector_code) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("ERROR: %s ch%0d en_in=%0b uv_in=%0d: expected en=%0b uv=%0d code=%0d, got en=%0b uv=%0d code=%0d",
							p.op.kind.name(), p.op.channel, p.op.enable_in, p.op.voltage_in_uv,
							p.rsp.enabled, p.rsp.voltage_out_uv, p.rsp.selector_code,
							got.enabled, got.voltage_out_uv, got.selector_code);
				end
			end
		end
	end

	// Readback right after reset: codes zero, voltages at range minimum
	task automatic test_reset_readback();
		send_op(make_op(KIND_GET_VOLT, 0, 1'b0, 0));
		send_op(make_op(KIND_GET_VOLT, 3, 1'b0, 0));
		send_op(make_op(KIND_GET_VOLT, 9, 1'b0, 0));
	endtask

	// Enable bits in both bytes, including the channels on the upper dcdc bits
	task automatic test_enable_map();
		send_op(make_op(KIND_SET_EN, 0, 1'b1, 0));
		send_op(make_op(KIND_SET_EN, 3, 1'b1, 22'h3FFFFF));
		send_op(make_op(KIND_SET_EN, 4, 1'b1, 0));
		send_op(make_op(KIND_SET_EN, 11, 1'b1, 0));
		send_op(make_op(KIND_SET_EN, 12, 1'b1, 0));
		idle_cycles(3);
		send_op(make_op(KIND_SET_EN, 13, 1'b1, 0));
		send_op(make_op(KIND_GET_EN, 1, 1'b1, 0));
		send_op(make_op(KIND_SET_EN, 0, 1'b0, 0));
	endtask

	// Clamping at both ends of the field and rounding up to the next step
	task automatic test_voltage_limits();
		send_op(make_op(KIND_SET_VOLT, 0, 1'b0, 0));
		send_op(make_op(KIND_SET_VOLT, 1, 1'b0, 22'h3FFFFF));
		send_op(make_op(KIND_GET_VOLT, 1, 1'b0, 0));
		send_op(make_op(KIND_SET_VOLT, 0, 1'b0, 712501));
		send_op(make_op(KIND_SET_VOLT, 3, 1'b0, 3400000));
		send_op(make_op(KIND_GET_VOLT, 3, 1'b0, 0));
		send_op(make_op(KIND_SET_VOLT, 6, 1'b1, 2450001));
		send_op(make_op(KIND_GET_VOLT, 6, 1'b0, 0));
		send_op(make_op(KIND_SET_VOLT, 7, 1'b0, 1800000));
	endtask

	// Fixed-output channels ignore set voltage; channels past the end read as zero
	task automatic test_fixed_and_unmapped();
		send_op(make_op(KIND_SET_VOLT, 2, 1'b0, 3000000));
		send_op(make_op(KIND_GET_VOLT, 2, 1'b0, 0));
		send_op(make_op(KIND_SET_VOLT, 13, 1'b0, 0));
		send_op(make_op(KIND_GET_VOLT, 13, 1'b0, 0));
		send_op(make_op(KIND_SET_EN, 14, 1'b1, 22'h2AAAAA));
		send_op(make_op(KIND_GET_VOLT, 15, 1'b1, 22'h155555));
	endtask

	// Random traffic in bursts: mostly set-then-get pairs on one channel
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned done_items, burst_left, ch, seq;
		bit          drained;
		req_t        ops [2];
		int unsigned n_ops;
		done_items = 0;
		drained    = 1'b0;
		burst_left = $urandom_range(1, 24);
		while (done_items < n_items) begin
			ch  = pick_channel();
			seq = $urandom_range(0, 9);
			if (seq < 4) begin
				ops[0] = make_op(KIND_SET_VOLT, ch, $urandom_range(0, 1), pick_voltage(ch));
				ops[1] = make_op(KIND_GET_VOLT, ch, $urandom_range(0, 1), pick_voltage(ch));
				n_ops  = 2;
			end else if (seq < 6) begin
				ops[0] = make_op(KIND_SET_EN, ch, $urandom_range(0, 1), pick_voltage(ch));
				ops[1] = make_op(KIND_GET_EN, ch, $urandom_range(0, 1), pick_voltage(ch));
				n_ops  = 2;
			end else begin
				ops[0] = make_op(kind_t'($urandom_range(0, 3)), ch, $urandom_range(0, 1),
					pick_voltage(ch));
				n_ops  = 1;
			end
			for (int i = 0; i < n_ops; i++) begin
				send_op(ops[i]);
				done_items++;
				burst_left--;
				if (!drained && done_items >= n_items / 2) begin
					wait_drain();
					drained = 1'b1;
				end else if (burst_left == 0) begin
					idle_cycles($urandom_range(1, 8));
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
						: $urandom_range(1, 24);
				end
			end
		end
		op_bus.valid <= 1'b0;
	endtask

	initial begin
		fail_count      = 0;
		mismatch_count  = 0;
		results_checked = 0;
		ops_sent        = 0;
		ops_by_kind     = '{default: 0};
		enable_regs     = '0;
		sel_codes       = '{default: '0};
		arst_n       <= 1'b0;
		op_bus.valid <= 1'b0;
		op_bus.data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_readback();
		test_enable_map();
		test_voltage_limits();
		test_fixed_and_unmapped();
		wait_drain();
		test_random_traffic(400);

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_q.size() != 0)
			fail_count++;

		$display("testbench: %0d operations (set-en %0d, get-en %0d, set-volt %0d, get-volt %0d)",
			ops_sent, ops_by_kind[KIND_SET_EN], ops_by_kind[KIND_GET_EN],
			ops_by_kind[KIND_SET_VOLT], ops_by_kind[KIND_GET_VOLT]);
		$display("testbench: %0d result beats checked, %0d mismatches",
			results_checked, mismatch_count);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
